FILE: src/right_triangle_third_vertex_defines.svh
// Assertion macros used by the block that checks its own pipeline.
`ifndef RIGHT_TRIANGLE_THIRD_VERTEX_DEFINES_SVH
`define RIGHT_TRIANGLE_THIRD_VERTEX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTTV_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pipeline check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTTV_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pipeline check failed");

`endif

FILE: src/rttv_pkg.sv
package rttv_pkg;

  localparam int SQ_STEPS  = 33;
  localparam int DIV_STEPS = 34;
  localparam int LATENCY   = 3 + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [15:0] MIN_DIST_RESET = 16'd66;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_COINCIDE = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [33:0] Q_CLAMP = 34'h2_0000_0000;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               negx;
    logic               negy;
    logic [62:0]        nx;
    logic [62:0]        ny;
  } carry_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               negx;
    logic               negy;
    logic               deg;
    logic               ovx;
    logic               ovy;
    logic [32:0]        d;
  } dcarry_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [33:0] numlo;
    logic [33:0] q;
  } lane_t;

endpackage

FILE: src/right_triangle_third_vertex.sv
// Fully pipelined: busy is always low, so a request may be started in every
// cycle, and each request gives exactly one result strobe, in the order the
// requests were taken. The pipeline is the 33-stage square root (one root bit per
// stage) followed by the 34-stage restoring divider (one quotient bit per
// stage), plus input, multiply, sum, check and output stages. The receiver
// cannot stall, so the pipeline never holds. A min_distance write takes
// effect for requests that reach the check stage after it.
`include "right_triangle_third_vertex_defines.svh"

module right_triangle_third_vertex (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_right_x,
  input  logic signed [31:0] in_right_y,
  input  logic signed [31:0] in_other_x,
  input  logic signed [31:0] in_other_y,
  input  logic signed [31:0] in_leg_length,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_third_x,
  output logic signed [31:0] out_third_y,
  output logic [1:0]         out_status
);
  import rttv_pkg::*;

  logic [15:0] min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RESET;
    end else if (cfg_we) begin
      min_dist_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Stage 1: differences.
  logic               s1_vld_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [31:0] s1_rx_r, s1_ry_r, s1_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    dx_r     <= {in_right_x[31], in_right_x} - {in_other_x[31], in_other_x};
    dy_r     <= {in_right_y[31], in_right_y} - {in_other_y[31], in_other_y};
    s1_rx_r  <= in_right_x;
    s1_ry_r  <= in_right_y;
    s1_len_r <= in_leg_length;
  end

  // Stage 2: magnitudes and products.
  logic [32:0] ax_full, ay_full;
  logic [31:0] ax, ay, al, al_full;
  logic        s2_vld_r, s2_negx_r, s2_negy_r;
  logic signed [31:0] s2_rx_r, s2_ry_r;
  logic [63:0] sqx_r, sqy_r, nx_full, ny_full;
  logic [62:0] s2_nx_r, s2_ny_r;

  assign ax_full = dx_r[32] ? 33'd0 - dx_r : dx_r;
  assign ay_full = dy_r[32] ? 33'd0 - dy_r : dy_r;
  assign ax      = ax_full[31:0];
  assign ay      = ay_full[31:0];
  assign al_full = s1_len_r[31] ? 32'd0 - s1_len_r : s1_len_r;
  assign al      = al_full;
  assign nx_full = ay * al;
  assign ny_full = ax * al;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    sqx_r     <= ax * ax;
    sqy_r     <= ay * ay;
    s2_nx_r   <= nx_full[62:0];
    s2_ny_r   <= ny_full[62:0];
    s2_negx_r <= dy_r[32] ^ s1_len_r[31];
    s2_negy_r <= (!dx_r[32] && (dx_r != 33'sd0)) ^ s1_len_r[31];
    s2_rx_r   <= s1_rx_r;
    s2_ry_r   <= s1_ry_r;
  end

  // Stage 3: sum of squares, then the square root stages.
  carry_t      cr_r   [SQ_STEPS+1];
  logic [65:0] rad_r  [SQ_STEPS+1];
  logic [33:0] srem_r [SQ_STEPS+1];
  logic [32:0] root_r [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r[0].vld <= 1'b0;
    end else begin
      cr_r[0].vld <= s2_vld_r;
    end
    cr_r[0].rx   <= s2_rx_r;
    cr_r[0].ry   <= s2_ry_r;
    cr_r[0].negx <= s2_negx_r;
    cr_r[0].negy <= s2_negy_r;
    cr_r[0].nx   <= s2_nx_r;
    cr_r[0].ny   <= s2_ny_r;
    rad_r[0]     <= {2'b00, sqx_r} + {2'b00, sqy_r};
    srem_r[0]    <= '0;
    root_r[0]    <= '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [35:0] rem_sh, trial, rem_dif;
    logic        ge;

    assign rem_sh  = {srem_r[k], rad_r[k][65:64]};
    assign trial   = {1'b0, root_r[k], 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_dif = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cr_r[k+1].vld <= 1'b0;
      end else begin
        cr_r[k+1].vld <= cr_r[k].vld;
      end
      cr_r[k+1].rx   <= cr_r[k].rx;
      cr_r[k+1].ry   <= cr_r[k].ry;
      cr_r[k+1].negx <= cr_r[k].negx;
      cr_r[k+1].negy <= cr_r[k].negy;
      cr_r[k+1].nx   <= cr_r[k].nx;
      cr_r[k+1].ny   <= cr_r[k].ny;
      rad_r[k+1]     <= {rad_r[k][63:0], 2'b00};
      srem_r[k+1]    <= ge ? rem_dif[33:0] : rem_sh[33:0];
      root_r[k+1]    <= {root_r[k][31:0], ge};
    end
  end

  // Check stage: coincidence test and quotient range test.
  dcarry_t dc_r   [DIV_STEPS+1];
  lane_t   lane_r [DIV_STEPS+1][2];
  carry_t  cq;
  logic [32:0] droot;

  assign cq    = cr_r[SQ_STEPS];
  assign droot = root_r[SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r[0].vld <= 1'b0;
    end else begin
      dc_r[0].vld <= cq.vld;
    end
    dc_r[0].rx   <= cq.rx;
    dc_r[0].ry   <= cq.ry;
    dc_r[0].negx <= cq.negx;
    dc_r[0].negy <= cq.negy;
    dc_r[0].deg  <= (droot == 33'd0) || (droot < {17'd0, min_dist_r});
    dc_r[0].ovx  <= {4'd0, cq.nx[62:34]} >= droot;
    dc_r[0].ovy  <= {4'd0, cq.ny[62:34]} >= droot;
    dc_r[0].d    <= droot;
    lane_r[0][0].rem   <= {5'd0, cq.nx[62:34]};
    lane_r[0][0].numlo <= cq.nx[33:0];
    lane_r[0][0].q     <= '0;
    lane_r[0][1].rem   <= {5'd0, cq.ny[62:34]};
    lane_r[0][1].numlo <= cq.ny[33:0];
    lane_r[0][1].q     <= '0;
  end

  // Restoring division, one quotient bit per stage in each lane.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dc_r[j+1].vld <= 1'b0;
      end else begin
        dc_r[j+1].vld <= dc_r[j].vld;
      end
      dc_r[j+1].rx   <= dc_r[j].rx;
      dc_r[j+1].ry   <= dc_r[j].ry;
      dc_r[j+1].negx <= dc_r[j].negx;
      dc_r[j+1].negy <= dc_r[j].negy;
      dc_r[j+1].deg  <= dc_r[j].deg;
      dc_r[j+1].ovx  <= dc_r[j].ovx;
      dc_r[j+1].ovy  <= dc_r[j].ovy;
      dc_r[j+1].d    <= dc_r[j].d;
    end

    for (genvar m = 0; m < 2; m++) begin : g_lane
      logic [33:0] rs, rdif;
      logic        ge;

      assign rs   = {lane_r[j][m].rem[32:0], lane_r[j][m].numlo[33]};
      assign ge   = rs >= {1'b0, dc_r[j].d};
      assign rdif = rs - {1'b0, dc_r[j].d};

      always_ff @(posedge clk) begin
        lane_r[j+1][m].rem   <= ge ? rdif : rs;
        lane_r[j+1][m].numlo <= {lane_r[j][m].numlo[32:0], 1'b0};
        lane_r[j+1][m].q     <= {lane_r[j][m].q[32:0], ge};
      end
    end
  end

  // Output stage: clamp, offset, saturate.
  dcarry_t fc;
  logic [33:0] qx, qy;
  logic [35:0] vx, vy, sx, sy;
  logic        hix, lox, hiy, loy;

  assign fc = dc_r[DIV_STEPS];
  assign qx = (fc.ovx || lane_r[DIV_STEPS][0].q > Q_CLAMP) ? Q_CLAMP
                                                           : lane_r[DIV_STEPS][0].q;
  assign qy = (fc.ovy || lane_r[DIV_STEPS][1].q > Q_CLAMP) ? Q_CLAMP
                                                           : lane_r[DIV_STEPS][1].q;
  assign vx  = fc.negx ? 36'd0 - {2'b00, qx} : {2'b00, qx};
  assign vy  = fc.negy ? 36'd0 - {2'b00, qy} : {2'b00, qy};
  assign sx  = {{4{fc.rx[31]}}, fc.rx} + vx;
  assign sy  = {{4{fc.ry[31]}}, fc.ry} + vy;
  assign hix = !sx[35] && (sx[34:31] != 4'h0);
  assign lox =  sx[35] && (sx[34:31] != 4'hF);
  assign hiy = !sy[35] && (sy[34:31] != 4'h0);
  assign loy =  sy[35] && (sy[34:31] != 4'hF);

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic [1:0]         out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fc.vld;
    end
    if (fc.deg) begin
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_status_r <= ST_COINCIDE;
    end else begin
      out_x_r      <= hix ? 32'h7FFF_FFFF : (lox ? 32'h8000_0000 : sx[31:0]);
      out_y_r      <= hiy ? 32'h7FFF_FFFF : (loy ? 32'h8000_0000 : sy[31:0]);
      out_status_r <= (hix || lox || hiy || loy) ? ST_SAT : ST_OK;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_third_x = out_x_r;
  assign out_third_y = out_y_r;
  assign out_status  = out_status_r;

  `RTTV_ASSERT_IMP(a_strobe_traces_request, out_valid, $past(start, LATENCY))
  `RTTV_ASSERT_IMP(a_coincide_zero, out_valid && (out_status == ST_COINCIDE),
                   (out_third_x == 32'sd0) && (out_third_y == 32'sd0))
  `RTTV_ASSERT_IMP(a_sat_at_limit, out_valid && (out_status == ST_SAT),
                   (out_third_x == 32'sh7FFF_FFFF) || (out_third_x == 32'sh8000_0000) ||
                   (out_third_y == 32'sh7FFF_FFFF) || (out_third_y == 32'sh8000_0000))
  `RTTV_ASSERT_NXT(a_check_to_div, cq.vld, dc_r[0].vld)

endmodule

FILE: tb/right_triangle_third_vertex_check.sv
module right_triangle_third_vertex_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_right_x,
  input  logic signed [31:0] in_right_y,
  input  logic signed [31:0] in_other_x,
  input  logic signed [31:0] in_other_y,
  input  logic signed [31:0] in_leg_length,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               out_valid,
  input  logic signed [31:0] out_third_x,
  input  logic signed [31:0] out_third_y,
  input  logic [1:0]         out_status,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rttv_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [1:0]         status;
  } vertex_t;

  vertex_t     vertex_q[$];
  logic [15:0] min_dist;

  function automatic longint shifted_coord(input longint base, input longint a,
                                           input longint len, input longint d,
                                           inout logic sat);
    longint unsigned num;
    longint unsigned quot;
    longint          s;
    num  = longint'(a < 0 ? -a : a) * longint'(len < 0 ? -len : len);
    quot = num / d;
    if (quot > 64'h2_0000_0000) quot = 64'h2_0000_0000;
    s = ((a < 0) != (len < 0)) ? base - longint'(quot) : base + longint'(quot);
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      s = 64'sd2147483647;
    end else if (s < -64'sd2147483648) begin
      sat = 1'b1;
      s = -64'sd2147483648;
    end
    return s;
  endfunction

  function automatic vertex_t third_vertex(input logic signed [31:0] rx, ry, hx, hy, len,
                                           input logic [15:0] md);
    longint      dx;
    longint      dy;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [65:0] sum;
    logic [32:0] root;
    logic [32:0] cand;
    logic        sat;
    vertex_t     v;
    dx = longint'(rx) - longint'(hx);
    dy = longint'(ry) - longint'(hy);
    ax = 33'(dx < 0 ? -dx : dx);
    ay = 33'(dy < 0 ? -dy : dy);
    sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = root | (33'd1 << b);
      if (66'(cand) * 66'(cand) <= sum) root = cand;
    end
    sat = 1'b0;
    if (root == 0 || root < 33'(md)) begin
      v.x = '0;
      v.y = '0;
      v.status = ST_COINCIDE;
    end else begin
      v.x = 32'(shifted_coord(longint'(rx), dy, longint'(len), longint'(root), sat));
      v.y = 32'(shifted_coord(longint'(ry), -dx, longint'(len), longint'(root), sat));
      v.status = sat ? ST_SAT : ST_OK;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    vertex_t want;
    if (!rst_n) begin
      min_dist <= MIN_DIST_RESET;
      vertex_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) min_dist <= cfg_wdata;
      if (out_valid) begin
        if (vertex_q.size() == 0) begin
          $display("%t: result with no request waiting: x %0d y %0d status %0d",
                   $time, out_third_x, out_third_y, out_status);
          errors <= errors + 1;
        end else begin
          want = vertex_q.pop_front();
          if (out_third_x !== want.x || out_third_y !== want.y ||
              out_status !== want.status) begin
            $display("%t: mismatch: expected x %0d y %0d status %0d, got x %0d y %0d status %0d",
                     $time, want.x, want.y, want.status,
                     out_third_x, out_third_y, out_status);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy)
        vertex_q.push_back(third_vertex(in_right_x, in_right_y, in_other_x, in_other_y,
                                        in_leg_length, min_dist));
      pending <= vertex_q.size();
    end
  end

endmodule

FILE: tb/right_triangle_third_vertex_test.sv
module right_triangle_third_vertex_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rttv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_right_x;
  logic signed [31:0] in_right_y;
  logic signed [31:0] in_other_x;
  logic signed [31:0] in_other_y;
  logic signed [31:0] in_leg_length;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;
  logic               out_valid;
  logic signed [31:0] out_third_x;
  logic signed [31:0] out_third_y;
  logic [1:0]         out_status;
  int                 errors;
  int                 pending;
  int                 cycles;
  logic               calm;

  right_triangle_third_vertex DUT (.*);
  right_triangle_third_vertex_check checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("right_triangle_third_vertex_test: done, errors");
      $finish;
    end
  end

  task automatic send_request(input logic signed [31:0] rx, ry, hx, hy, len);
    start         <= 1'b1;
    in_right_x    <= rx;
    in_right_y    <= ry;
    in_other_x    <= hx;
    in_other_y    <= hy;
    in_leg_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    while (!calm && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_min_distance(input logic [15:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      2: return $urandom_range(1) ? 32'sh7fff_ffff - $urandom_range(255)
                                  : 32'sh8000_0000 + $urandom_range(255);
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] c);
    case ($urandom_range(3))
      0: return c;
      1: return c + $signed($urandom_range(0, 200)) - 100;
      2: return c + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: return any_coord();
    endcase
  endfunction

  task automatic random_burst(input int count);
    logic signed [31:0] rx, ry;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      rx = any_coord();
      ry = any_coord();
      send_request(rx, ry, near(rx), near(ry),
                   $urandom_range(1) ? $urandom : any_coord());
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_right_x = '0;
    in_right_y = '0;
    in_other_x = '0;
    in_other_y = '0;
    in_leg_length = '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(0, 0, 0, 0, 32'sh0001_0000);
    send_request(100, 0, 35, 0, 32'sh0001_0000);
    send_request(100, 0, 34, 0, 32'sh0001_0000);
    send_request(32'sh0001_0000, 32'sh0002_0000, 0, 0, 32'sh0003_0000);
    send_request(32'sh0001_0000, 32'sh0002_0000, 0, 0, -32'sh0003_0000);
    send_request(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff);
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh8000_0000);
    send_request(32'sh7fff_ffff, 0, 32'sh7fff_fff0, 0, 32'sh8000_0000);
    send_request(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_0000, 32'sh7fff_ffff,
                 32'sh7fff_ffff);
    send_request(0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(0, 0, 1, 0, 32'sh8000_0000);
    send_request(5, 7, 5, 7, 32'sh7fff_ffff);
    send_request(32'sh0010_0000, -32'sh0010_0000, -32'sh0010_0000, 32'sh0010_0000, 0);
    send_request(32'shffff_ffff, 32'shffff_ffff, 0, 0, 32'shffff_ffff);
    random_burst(300);

    write_min_distance(16'd0);
    send_request(0, 0, 0, 0, 32'sh0001_0000);
    send_request(0, 0, 1, 0, 32'sh7fff_ffff);
    send_request(3, 4, 0, 0, -32'sh7fff_ffff);
    random_burst(300);

    write_min_distance(16'hffff);
    send_request(32'sh0000_ffff, 0, 0, 0, 32'sh0001_0000);
    send_request(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000);
    send_request(32'sh0000_ffff, 32'sh0000_0001, 0, 0, 32'sh0001_0000);
    random_burst(300);

    write_min_distance(16'd1);
    random_burst(250);

    write_min_distance(16'($urandom_range(2, 16'hfffe)));
    random_burst(300);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("right_triangle_third_vertex_test: done, clean");
    else
      $display("right_triangle_third_vertex_test: done, errors");
    $finish;
  end

endmodule
